@@ hw/rtl/mqe_pkg.sv @@
package mqe_pkg;

  localparam int QUEUE_COUNT = 1024;
  localparam int CAPACITY    = 4096;
  localparam int DATA_WIDTH  = 32;

  localparam int QW    = $clog2(QUEUE_COUNT);
  localparam int EW    = $clog2(CAPACITY);
  localparam int CW    = EW + 1;
  localparam int QIU_W = 11;
  localparam logic [QIU_W-1:0] QIU_RESET = QIU_W'(1024);

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_FRONT = 2'd1,
    OP_DEQ   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CLS_RUN,
    CLS_NOP,
    CLS_BAD
  } cls_e;

  typedef struct packed {
    op_e                          op;
    cls_e                         cls;
    logic [QW-1:0]                queue;
    logic signed [DATA_WIDTH-1:0] value;
  } item_t;

  typedef struct packed {
    logic          nonempty;
    logic [EW-1:0] head;
    logic [EW-1:0] tail;
  } qent_t;

endpackage

@@ hw/rtl/mqe_if.sv @@
interface mqe_in_if;
  import mqe_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic [QW-1:0]                queue_index;
  logic signed [DATA_WIDTH-1:0] value;
  modport source (output valid, output opcode, output queue_index, output value, input ready);
  modport sink   (input valid, input opcode, input queue_index, input value, output ready);
endinterface

interface mqe_out_if;
  import mqe_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] front_value;
  logic [1:0]                   status;
  modport source (output valid, output front_value, output status, input ready);
  modport sink   (input valid, input front_value, input status, output ready);
endinterface

@@ hw/rtl/mqe_front.sv @@
module mqe_front (
  mqe_in_if.sink                      in_if,
  input  logic [mqe_pkg::QIU_W-1:0]   queues_in_use_i,
  input  logic                        clear_done_i,
  output logic                        push_valid_o,
  output mqe_pkg::item_t              push_data_o,
  input  logic                        push_ready_i
);
  import mqe_pkg::*;

  // Bad index and unused opcodes are settled here so the back end skips the tables.
  always_comb begin
    push_data_o.op    = op_e'(in_if.opcode);
    push_data_o.queue = in_if.queue_index;
    push_data_o.value = in_if.value;
    if (op_e'(in_if.opcode) == OP_NONE) begin
      push_data_o.cls = CLS_NOP;
    end else if ({1'b0, in_if.queue_index} >= queues_in_use_i) begin
      push_data_o.cls = CLS_BAD;
    end else begin
      push_data_o.cls = CLS_RUN;
    end
  end

  assign in_if.ready  = push_ready_i & clear_done_i;
  assign push_valid_o = in_if.valid & clear_done_i;

endmodule

@@ hw/rtl/mqe_fifo.sv @@
module mqe_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  mqe_pkg::item_t push_data_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output mqe_pkg::item_t pop_data_o,
  input  logic           pop_ready_i
);
  import mqe_pkg::*;

  item_t       slot_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = slot_q[rd_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_d  = wr_q ^ do_push;
    rd_d  = rd_q ^ do_pop;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/mqe_back.sv @@
module mqe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  mqe_pkg::item_t pop_data_i,
  output logic           pop_ready_o,
  output logic           clear_done_o,
  mqe_out_if.source      out_if
);
  import mqe_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [QW-1:0] clr_q, clr_d;
  item_t         item_q, item_d;
  logic [CW-1:0] fresh_q, fresh_d, rcnt_q, rcnt_d;
  logic [EW-1:0] rhead_q, rhead_d, alloc_q, alloc_d;
  logic          ovalid_q, ovalid_d;
  logic signed [DATA_WIDTH-1:0] ofront_q, ofront_d;
  status_e       ostat_q, ostat_d;

  // Queue table: nonempty flag, head and tail per queue.
  qent_t                        qtab_mem [QUEUE_COUNT];
  qent_t                        qtab_rd_q, qtab_wd;
  logic                         qtab_we, qtab_re;
  logic [QW-1:0]                qtab_wa;
  // Entry store: value and link in separate arrays.
  logic signed [DATA_WIDTH-1:0] val_mem [CAPACITY];
  logic signed [DATA_WIDTH-1:0] val_rd_q, val_wd;
  logic                         val_we, val_re;
  logic [EW-1:0]                val_wa, val_ra;
  logic [EW-1:0]                link_mem [CAPACITY];
  logic [EW-1:0]                link_rd_q, link_wd, link_wa, link_ra;
  logic                         link_we, link_re;

  logic          pop;
  logic [EW-1:0] e_new;

  assign clear_done_o = (state_q != S_CLEAR);
  assign pop          = (state_q == S_IDLE) & pop_valid_i & ~ovalid_q;
  assign pop_ready_o  = pop;
  assign out_if.valid       = ovalid_q;
  assign out_if.front_value = ofront_q;
  assign out_if.status      = ostat_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    item_d   = item_q;
    fresh_d  = fresh_q;
    rcnt_d   = rcnt_q;
    rhead_d  = rhead_q;
    alloc_d  = alloc_q;
    ovalid_d = ovalid_q & ~out_if.ready;
    ofront_d = ofront_q;
    ostat_d  = ostat_q;
    qtab_we  = 1'b0;
    qtab_wa  = item_q.queue;
    qtab_wd  = qtab_rd_q;
    qtab_re  = 1'b0;
    val_we   = 1'b0;
    val_wa   = alloc_q;
    val_wd   = item_q.value;
    val_re   = 1'b0;
    val_ra   = qtab_rd_q.head;
    link_we  = 1'b0;
    link_wa  = alloc_q;
    link_wd  = alloc_q;
    link_re  = 1'b0;
    link_ra  = rhead_q;
    e_new    = rhead_q;
    unique case (state_q)
      S_CLEAR: begin
        qtab_we = 1'b1;
        qtab_wa = clr_q;
        qtab_wd = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == QW'(QUEUE_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop) begin
          item_d   = pop_data_i;
          ofront_d = '0;
          unique case (pop_data_i.cls)
            CLS_NOP: begin
              ovalid_d = 1'b1;
              ostat_d  = ST_OK;
            end
            CLS_BAD: begin
              ovalid_d = 1'b1;
              ostat_d  = ST_BAD;
            end
            default: begin
              qtab_re = 1'b1;
              link_re = 1'b1;
              state_d = S_LOOK;
            end
          endcase
        end
        qtab_wa = pop_data_i.queue;
      end
      S_LOOK: begin
        state_d = S_IDLE;
        if (item_q.op == OP_ENQ) begin
          priority if (rcnt_q != '0) begin
            e_new   = rhead_q;
            rhead_d = link_rd_q;
            rcnt_d  = rcnt_q - 1'b1;
          end else if (fresh_q < CW'(CAPACITY)) begin
            e_new   = fresh_q[EW-1:0];
            fresh_d = fresh_q + 1'b1;
          end else begin
            ovalid_d = 1'b1;
            ostat_d  = ST_FULL;
          end
          if (rcnt_q != '0 || fresh_q < CW'(CAPACITY)) begin
            val_we   = 1'b1;
            val_wa   = e_new;
            link_we  = 1'b1;
            link_wa  = e_new;
            link_wd  = e_new;
            qtab_we  = 1'b1;
            qtab_wd.nonempty = 1'b1;
            qtab_wd.head = qtab_rd_q.nonempty ? qtab_rd_q.head : e_new;
            qtab_wd.tail = e_new;
            alloc_d  = e_new;
            if (qtab_rd_q.nonempty) begin
              // The old tail still has to be linked to the new entry.
              state_d = S_FIN;
            end else begin
              ovalid_d = 1'b1;
              ostat_d  = ST_OK;
            end
          end
        end else if (!qtab_rd_q.nonempty) begin
          ovalid_d = 1'b1;
          ostat_d  = ST_EMPTY;
        end else begin
          val_re  = (item_q.op == OP_FRONT);
          link_re = (item_q.op == OP_DEQ);
          link_ra = qtab_rd_q.head;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        state_d  = S_IDLE;
        ovalid_d = 1'b1;
        ostat_d  = ST_OK;
        unique case (item_q.op)
          OP_ENQ: begin
            link_we = 1'b1;
            link_wa = qtab_rd_q.tail;
            link_wd = alloc_q;
          end
          OP_FRONT: begin
            ofront_d = val_rd_q;
          end
          default: begin
            qtab_we = 1'b1;
            if (qtab_rd_q.head == qtab_rd_q.tail) begin
              qtab_wd.nonempty = 1'b0;
            end else begin
              qtab_wd.head = link_rd_q;
            end
            // The freed entry goes on top of the free list.
            link_we = 1'b1;
            link_wa = qtab_rd_q.head;
            link_wd = rhead_q;
            rhead_d = qtab_rd_q.head;
            rcnt_d  = rcnt_q + 1'b1;
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      fresh_q  <= '0;
      rcnt_q   <= '0;
      rhead_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      fresh_q  <= fresh_d;
      rcnt_q   <= rcnt_d;
      rhead_q  <= rhead_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    alloc_q  <= alloc_d;
    ofront_q <= ofront_d;
    ostat_q  <= ostat_d;
  end

  always_ff @(posedge clk_i) begin
    if (qtab_we) begin
      qtab_mem[qtab_wa] <= qtab_wd;
    end
    if (qtab_re) begin
      qtab_rd_q <= qtab_mem[pop_data_i.queue];
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (val_re) begin
      val_rd_q <= val_mem[val_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (link_re) begin
      link_rd_q <= link_mem[link_ra];
    end
  end

endmodule

@@ hw/rtl/multi_queue_engine.sv @@
// Paths: a bad index or unused opcode is answered from the idle state; enqueue to an empty
// queue and any empty/full result end in the lookup state; front, dequeue and enqueue to a
// nonempty queue go on to the finish state. Items pass a two-entry queue between the ends.
// The back end takes no new item until it is idle and its last result has been taken; it runs
// one item at a time through the queue table and the link store.
// Reset: asynchronous, active low; afterwards a pass over all 1024 queue entries clears the
// queue table while no item is accepted. Configuration writes are taken at any time.
module multi_queue_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mqe_pkg::QIU_W-1:0] cfg_wdata_i,
  mqe_in_if.sink                    in_if,
  mqe_out_if.source                 out_if
);
  import mqe_pkg::*;

  logic [QIU_W-1:0] qiu_q;
  logic             push_valid, push_ready, pop_valid, pop_ready, clear_done;
  item_t            push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qiu_q <= QIU_RESET;
    end else if (cfg_we_i) begin
      qiu_q <= cfg_wdata_i;
    end
  end

  mqe_front u_front (
    .in_if           (in_if),
    .queues_in_use_i (qiu_q),
    .clear_done_i    (clear_done),
    .push_valid_o    (push_valid),
    .push_data_o     (push_data),
    .push_ready_i    (push_ready)
  );

  mqe_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  mqe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_data_i   (pop_data),
    .pop_ready_o  (pop_ready),
    .clear_done_o (clear_done),
    .out_if       (out_if)
  );

endmodule

@@ hw/rtl/mqe_checker.sv @@
module mqe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_status_i,
  input logic [31:0] out_front_i
);
  import mqe_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) &&
    $stable(out_front_i))
    else $error("result changed while stalled");

  a_front_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_front_i != '0 |-> out_status_i == ST_OK)
    else $error("nonzero front value with a failing status");

  a_clear_blocks: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_i)
    else $error("item accepted during the table clearing pass");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result shown right after reset");

endmodule

bind multi_queue_engine mqe_checker u_mqe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .out_status_i (out_if.status),
  .out_front_i  (out_if.front_value)
);
